[rtl/core/avh_pkg.sv]
// shared types, sizes and codes for the averaging histogram
// no dependencies; used by every file in rtl/core except avh_ram
package avh_pkg;

	localparam int NUM_BINS     = 1024;
	localparam int COUNT_BITS   = 16;
	localparam int SAMPLE_BITS  = 24;
	localparam int SUM_BITS     = SAMPLE_BITS + COUNT_BITS;
	localparam int ADDR_BITS    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int WORD_BITS    = SUM_BITS + COUNT_BITS;
	localparam int DIV_CNT_BITS = $clog2(SUM_BITS + 1);

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	typedef enum logic [1:0] {
		ACT_ADD   = 2'd0,
		ACT_VEC   = 2'd1,
		ACT_READ  = 2'd2,
		ACT_CLEAR = 2'd3
	} avh_act_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_LONG  = 2'd2,
		ST_SAT   = 2'd3
	} avh_status_t;

	typedef struct packed {
		avh_act_t                action;
		logic [11:0]             bin_index;
		logic signed [23:0]      sample;
		logic [12:0]             vector_length;
	} avh_cmd_t;

	typedef struct packed {
		logic signed [23:0]      average;
		logic [15:0]             bin_count;
		avh_status_t             status;
	} avh_res_t;

	// low 16 bits of a bin count, zero extended when the count is narrower
	function automatic logic [15:0] cnt_to16(input logic [COUNT_BITS-1:0] c);
		logic [31:0] wide;
		wide = 32'(c);
		return wide[15:0];
	endfunction

endpackage

[rtl/core/avh_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module avh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/avh_div.sv]
// bit-serial signed-by-unsigned divider, one quotient bit per cycle
// depends on avh_pkg
module avh_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                go,
	input  logic signed [avh_pkg::SUM_BITS-1:0] dividend,
	input  logic [avh_pkg::COUNT_BITS-1:0]      divisor,
	output logic                                done,
	output logic signed [23:0]                  quotient
);

	logic [avh_pkg::SUM_BITS-1:0]     quo_q;
	logic [avh_pkg::COUNT_BITS-1:0]   rem_q;
	logic [avh_pkg::COUNT_BITS-1:0]   div_q;
	logic [avh_pkg::DIV_CNT_BITS-1:0] cnt_q;
	logic                             neg_q;
	logic                             run_q;
	logic                             done_q;

	logic [avh_pkg::SUM_BITS-1:0]     mag;
	logic [avh_pkg::COUNT_BITS:0]     trial;
	logic [avh_pkg::COUNT_BITS:0]     diff;
	logic                             ge;
	logic [avh_pkg::COUNT_BITS-1:0]   nrem;
	logic [avh_pkg::SUM_BITS-1:0]     qfull;
	logic                             last;

	assign mag   = dividend[avh_pkg::SUM_BITS-1] ? (~dividend + 1'b1) : dividend;
	assign trial = {rem_q, quo_q[avh_pkg::SUM_BITS-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = trial >= {1'b0, div_q};
	assign nrem  = ge ? diff[avh_pkg::COUNT_BITS-1:0] : trial[avh_pkg::COUNT_BITS-1:0];
	assign last  = cnt_q == avh_pkg::DIV_CNT_BITS'(avh_pkg::SUM_BITS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			div_q  <= '0;
			cnt_q  <= '0;
			neg_q  <= 1'b0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && !go && last;
			if (go) begin
				quo_q <= mag;
				rem_q <= '0;
				div_q <= divisor;
				neg_q <= dividend[avh_pkg::SUM_BITS-1];
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				rem_q <= nrem;
				quo_q <= {quo_q[avh_pkg::SUM_BITS-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	assign qfull    = neg_q ? (~quo_q + 1'b1) : quo_q;
	assign quotient = qfull[23:0];
	assign done     = done_q;

endmodule

[rtl/core/averaging_histogram_bins_core.sv]
// top level of the averaging histogram: command sequencer, bin store, divider
// depends on avh_pkg, avh_ram, avh_div
//
// One command is taken when start is high and busy is low; its result appears
// on result for a single cycle with done high and cannot be held off. Add and
// vector add read the bin and then write it back, with busy high for the write back.
// Index and length errors answer the cycle after the command with busy staying
// low. A read of a non-empty bin runs the bit-serial divider, one quotient bit
// per cycle, and its result follows when the divider is done. Clear, and reset
// itself, sweep the bin store one entry per cycle with busy high; a clear
// answers at the end of its sweep.
module averaging_histogram_bins_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  avh_pkg::avh_cmd_t cmd,
	output logic              done,
	output avh_pkg::avh_res_t result
);

	typedef enum logic [3:0] {
		S_CLR  = 4'b0001,
		S_IDLE = 4'b0010,
		S_RD   = 4'b0100,
		S_DIV  = 4'b1000
	} state_t;

	state_t                          state_q;
	logic [avh_pkg::ADDR_BITS-1:0]   ptr_q;
	logic                            clr_rsp_q;
	logic                            done_q;
	avh_pkg::avh_res_t               res_q;
	avh_pkg::avh_act_t               act_q;
	logic [avh_pkg::ADDR_BITS-1:0]   idx_q;
	logic signed [23:0]              smp_q;
	logic [avh_pkg::COUNT_BITS-1:0]  cnt_q;

	logic                            ram_we;
	logic [avh_pkg::ADDR_BITS-1:0]   ram_waddr;
	logic [avh_pkg::WORD_BITS-1:0]   ram_wdata;
	logic [avh_pkg::WORD_BITS-1:0]   ram_rdata;

	logic signed [avh_pkg::SUM_BITS-1:0] rd_sum;
	logic [avh_pkg::COUNT_BITS-1:0]      rd_cnt;
	logic [avh_pkg::COUNT_BITS-1:0]      inc_cnt;
	logic signed [avh_pkg::SUM_BITS-1:0] new_sum;
	logic                                sat;
	logic                                vlong;
	logic                                rng;
	logic                                div_go;
	logic                                div_done;
	logic signed [23:0]                  div_quo;

	assign rd_sum  = ram_rdata[avh_pkg::SUM_BITS-1:0];
	assign rd_cnt  = ram_rdata[avh_pkg::WORD_BITS-1:avh_pkg::SUM_BITS];
	assign inc_cnt = rd_cnt + 1'b1;
	assign new_sum = rd_sum + avh_pkg::SUM_BITS'(smp_q);
	assign sat     = rd_cnt == avh_pkg::CNT_MAX;

	assign vlong = (cmd.action == avh_pkg::ACT_VEC) &&
		(cmd.vector_length > 13'(avh_pkg::NUM_BINS));
	assign rng   = ((cmd.action == avh_pkg::ACT_VEC) &&
		({1'b0, cmd.bin_index} >= cmd.vector_length)) ||
		({1'b0, cmd.bin_index} >= 13'(avh_pkg::NUM_BINS));

	assign div_go = (state_q == S_RD) && (act_q == avh_pkg::ACT_READ) && (rd_cnt != '0);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = {inc_cnt, new_sum};
		case (state_q)
			S_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q;
				ram_wdata = '0;
			end
			S_RD: begin
				ram_we = (act_q != avh_pkg::ACT_READ) && !sat;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	avh_ram #(
		.WIDTH(avh_pkg::WORD_BITS),
		.DEPTH(avh_pkg::NUM_BINS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(cmd.bin_index[avh_pkg::ADDR_BITS-1:0]),
		.rdata(ram_rdata)
	);

	avh_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (div_go),
		.dividend(rd_sum),
		.divisor (rd_cnt),
		.done    (div_done),
		.quotient(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			ptr_q     <= '0;
			clr_rsp_q <= 1'b0;
			done_q    <= 1'b0;
			res_q     <= '0;
			act_q     <= avh_pkg::ACT_ADD;
			idx_q     <= '0;
			smp_q     <= '0;
			cnt_q     <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					if (ptr_q == avh_pkg::ADDR_BITS'(avh_pkg::NUM_BINS - 1)) begin
						ptr_q     <= '0;
						state_q   <= S_IDLE;
						clr_rsp_q <= 1'b0;
						done_q    <= clr_rsp_q;
						if (clr_rsp_q) begin
							res_q <= '{average: '0, bin_count: '0, status: avh_pkg::ST_OK};
						end
					end else begin
						ptr_q  <= ptr_q + 1'b1;
						done_q <= 1'b0;
					end
				end
				S_IDLE: begin
					if (start) begin
						act_q <= cmd.action;
						idx_q <= cmd.bin_index[avh_pkg::ADDR_BITS-1:0];
						smp_q <= cmd.sample;
						if (cmd.action == avh_pkg::ACT_CLEAR) begin
							clr_rsp_q <= 1'b1;
							state_q   <= S_CLR;
							done_q    <= 1'b0;
						end else if (vlong) begin
							done_q <= 1'b1;
							res_q  <= '{average: '0, bin_count: '0, status: avh_pkg::ST_LONG};
						end else if (rng) begin
							done_q <= 1'b1;
							res_q  <= '{average: '0, bin_count: '0, status: avh_pkg::ST_RANGE};
						end else begin
							state_q <= S_RD;
							done_q  <= 1'b0;
						end
					end else begin
						done_q <= 1'b0;
					end
				end
				S_RD: begin
					cnt_q <= rd_cnt;
					if (act_q == avh_pkg::ACT_READ) begin
						if (rd_cnt == '0) begin
							done_q  <= 1'b1;
							res_q   <= '{average: '0, bin_count: '0, status: avh_pkg::ST_OK};
							state_q <= S_IDLE;
						end else begin
							done_q  <= 1'b0;
							state_q <= S_DIV;
						end
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
						if (sat) begin
							res_q <= '{average: '0, bin_count: avh_pkg::cnt_to16(rd_cnt),
								status: avh_pkg::ST_SAT};
						end else begin
							res_q <= '{average: '0, bin_count: avh_pkg::cnt_to16(inc_cnt),
								status: avh_pkg::ST_OK};
						end
					end
				end
				S_DIV: begin
					done_q <= div_done;
					if (div_done) begin
						res_q   <= '{average: div_quo, bin_count: avh_pkg::cnt_to16(cnt_q),
							status: avh_pkg::ST_OK};
						state_q <= S_IDLE;
					end
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = res_q;

endmodule

[rtl/core/avh_chk.sv]
// port-level checker for averaging_histogram_bins_core, attached by bind
// depends on avh_pkg
module avh_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input avh_pkg::avh_cmd_t cmd,
	input logic              done,
	input avh_pkg::avh_res_t result
);

	logic acc;
	assign acc = start && !busy;

	// a clear sweeps the store, so the block is busy right after it
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc && cmd.action == avh_pkg::ACT_CLEAR |=> busy)
		else $error("clear transaction did not start a sweep");

	// a plain add to a bin past the end answers at once with a range error
	a_add_range: assert property (@(posedge clk) disable iff (!arst_n)
		acc && cmd.action == avh_pkg::ACT_ADD &&
		({1'b0, cmd.bin_index} >= 13'(avh_pkg::NUM_BINS))
		|=> done && result.status == avh_pkg::ST_RANGE)
		else $error("out-of-range add not flagged");

	// only a good read carries a nonzero average
	a_err_avg: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != avh_pkg::ST_OK |-> result.average == '0)
		else $error("nonzero average on error result");

	// a saturated bin reports the full count
	a_sat_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == avh_pkg::ST_SAT |->
		result.bin_count == avh_pkg::cnt_to16(avh_pkg::CNT_MAX))
		else $error("saturated result with wrong count");

	// a range or length error answers the cycle after its transaction
	a_err_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == avh_pkg::ST_RANGE || result.status == avh_pkg::ST_LONG)
		|-> $past(acc))
		else $error("late error result");

endmodule

bind averaging_histogram_bins_core avh_chk u_avh_chk (.*);

[test/avh_checker.sv]
// checker for the averaging histogram: watches commands and results, keeps
// its own copy of the bin sums and counts and compares every result transaction
// depends on avh_pkg
module avh_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  avh_pkg::avh_cmd_t cmd,
	input  logic              done,
	input  avh_pkg::avh_res_t result,
	output int                fail_count,
	output int                outstanding
);
	import avh_pkg::*;

	logic signed [SUM_BITS-1:0] sum_store [NUM_BINS];
	logic [COUNT_BITS-1:0]      count_store [NUM_BINS];
	avh_res_t                   awaited_results [$];
	int                         mismatches = 0;

	function automatic void wipe_bins();
		for (int i = 0; i < NUM_BINS; i++) begin
			sum_store[i]   = '0;
			count_store[i] = '0;
		end
	endfunction

	function automatic avh_res_t predict_bin_result(input avh_cmd_t c);
		avh_res_t           r;
		int unsigned        idx;
		int unsigned        vlen;
		logic signed [23:0] smp;
		logic signed [63:0] quot;
		r        = '0;
		r.status = ST_OK;
		idx      = 32'(c.bin_index);
		vlen     = 32'(c.vector_length);
		smp      = c.sample;
		if (c.action == ACT_CLEAR) begin
			wipe_bins();
			return r;
		end
		if (c.action == ACT_VEC && vlen > NUM_BINS) begin
			r.status = ST_LONG;
			return r;
		end
		if (c.action == ACT_VEC && idx >= vlen) begin
			r.status = ST_RANGE;
			return r;
		end
		if (idx >= NUM_BINS) begin
			r.status = ST_RANGE;
			return r;
		end
		if (c.action == ACT_READ) begin
			if (count_store[idx] != '0) begin
				quot      = 64'(sum_store[idx]) / $signed(64'(count_store[idx]));
				r.average = quot[23:0];
			end
			r.bin_count = 16'(count_store[idx]);
			return r;
		end
		// add and vector element add
		if (count_store[idx] == CNT_MAX) begin
			r.bin_count = 16'(count_store[idx]);
			r.status    = ST_SAT;
			return r;
		end
		sum_store[idx]   = sum_store[idx] + SUM_BITS'(smp);
		count_store[idx] = count_store[idx] + 1'b1;
		r.bin_count      = 16'(count_store[idx]);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		avh_res_t want;
		if (!arst_n) begin
			wipe_bins();
			awaited_results.delete();
			fail_count  <= mismatches;
			outstanding <= 0;
		end else begin
			if (start && !busy)
				awaited_results.push_back(predict_bin_result(cmd));
			if (done) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("unexpected transaction", 64'(result), 64'd0);
				end else begin
					want = awaited_results.pop_front();
					if (result.average !== want.average)
						report_mismatch("average", 64'(result.average), 64'(want.average));
					if (result.bin_count !== want.bin_count)
						report_mismatch("bin_count", 64'(result.bin_count),
							64'(want.bin_count));
					if (result.status !== want.status)
						report_mismatch("status", 64'(result.status), 64'(want.status));
				end
			end
			fail_count  <= mismatches;
			outstanding <= awaited_results.size();
		end
	end

endmodule

[test/tb_averaging_histogram_bins_core.sv]
// testbench top for averaging_histogram_bins_core: directed commands and
// random traffic; checking is done in avh_checker
// depends on avh_pkg, avh_checker and the core
module tb_averaging_histogram_bins_core;
	import avh_pkg::*;

	localparam int RANDOM_ITEMS = 950;

	logic     clk    = 1'b0;
	logic     arst_n = 1'b0;
	logic     start  = 1'b0;
	avh_cmd_t cmd    = '0;
	logic     busy;
	logic     done;
	avh_res_t result;
	int       fail_count;
	int       outstanding;
	int       sent = 0;
	bit       drained_once = 1'b0;

	always #1 clk = ~clk;

	averaging_histogram_bins_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	avh_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.done        (done),
		.result      (result),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	function automatic avh_cmd_t mk(input avh_act_t a, input int idx, input int smp,
			input int vl);
		avh_cmd_t c;
		c.action        = a;
		c.bin_index     = idx[11:0];
		c.sample        = smp[23:0];
		c.vector_length = vl[12:0];
		return c;
	endfunction

	function automatic int rand_sample();
		case ($urandom_range(0, 9))
			0: return -8388608;
			1: return 8388607;
			2: return 0;
			3: return -1;
			default: return int'($urandom_range(0, 16777215));
		endcase
	endfunction

	// mostly a few hot bins so reads see real averages
	function automatic int rand_index();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12)
			return $urandom_range(0, 15);
		if (r < 16)
			return $urandom_range(0, NUM_BINS - 1);
		if (r < 17)
			return NUM_BINS - 1;
		return $urandom_range(0, 4095);
	endfunction

	task automatic issue(input avh_cmd_t c);
		cmd   <= c;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	task automatic pause(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
	endtask

	task automatic random_item(input avh_cmd_t c);
		issue(c);
		sent++;
		if (!drained_once && sent >= 400) begin
			drained_once = 1'b1;
			drain();
		end else if (sent < RANDOM_ITEMS - 120 && (sent / 80) % 3 != 2
				&& $urandom_range(0, 5) == 0) begin
			pause($urandom_range(1, 9));
		end
	endtask

	initial begin
		int kind;
		int vl;
		int first;
		int n;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed
		issue(mk(ACT_READ, 0, 0, 0));
		issue(mk(ACT_ADD, 0, 8388607, 8191));
		issue(mk(ACT_ADD, 0, 8388607, 0));
		issue(mk(ACT_READ, 0, 0, 0));
		issue(mk(ACT_ADD, NUM_BINS - 1, -8388608, 0));
		issue(mk(ACT_READ, NUM_BINS - 1, -1, 8191));
		issue(mk(ACT_ADD, NUM_BINS, 1, 0));
		issue(mk(ACT_ADD, 4095, -1, 0));
		issue(mk(ACT_READ, 4095, 0, 0));
		issue(mk(ACT_ADD, 7, -3, 0));
		issue(mk(ACT_ADD, 7, 0, 0));
		issue(mk(ACT_READ, 7, 0, 0));
		issue(mk(ACT_VEC, 0, 9, 0));
		issue(mk(ACT_VEC, NUM_BINS - 1, 8388607, NUM_BINS));
		issue(mk(ACT_VEC, NUM_BINS, 1, NUM_BINS));
		issue(mk(ACT_VEC, 0, 1, NUM_BINS + 1));
		issue(mk(ACT_VEC, 4095, -1, 8191));
		issue(mk(ACT_VEC, 2, 5, 3));
		issue(mk(ACT_READ, NUM_BINS - 1, 0, 0));
		issue(mk(ACT_CLEAR, 4095, -1, 8191));
		issue(mk(ACT_READ, 0, 0, 0));
		issue(mk(ACT_READ, 7, 0, 0));

		issue(mk(ACT_ADD, 3, 8388607, 0));
		issue(mk(ACT_VEC, 3, -8388608, 4));
		issue(mk(ACT_READ, 3, 0, 0));
		issue(mk(ACT_CLEAR, 0, 0, 0));
		drain();

		// random traffic
		while (sent < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 99);
			if (kind < 35) begin
				random_item(mk(ACT_ADD, rand_index(), rand_sample(), $urandom_range(0, 8191)));
			end else if (kind < 60) begin
				vl    = ($urandom_range(0, 9) == 0) ? NUM_BINS : $urandom_range(1, 12);
				n     = (vl < 6) ? vl : 6;
				first = $urandom_range(0, vl - n);
				for (int i = first; i < first + n; i++)
					random_item(mk(ACT_VEC, i, rand_sample(), vl));
			end else if (kind < 65) begin
				random_item(mk(ACT_VEC, $urandom_range(0, 4095), rand_sample(),
					$urandom_range(0, 8191)));
			end else if (kind < 98) begin
				random_item(mk(ACT_READ, rand_index(), rand_sample(), $urandom_range(0, 8191)));
			end else begin
				random_item(mk(ACT_CLEAR, $urandom_range(0, 4095), rand_sample(),
					$urandom_range(0, 8191)));
			end
		end

		drain();
		repeat (64) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#20000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
